@@ hdl/rec_pkg.sv @@
package rec_pkg;

  localparam int unsigned TABLE_COLUMNS = 16;
  localparam int unsigned MAX_ROTORS    = 12;

  localparam int unsigned FRONT_STAGES  = 4;
  localparam int unsigned SQRT_STAGES   = 32;
  localparam int unsigned QUOT_BITS     = 17;
  localparam int unsigned COLUMN_STAGES = 4;
  localparam int unsigned LATENCY = FRONT_STAGES + SQRT_STAGES + QUOT_BITS + COLUMN_STAGES;

  localparam logic [1:0] ST_WRITTEN   = 2'd0;
  localparam logic [1:0] ST_ZERO_AXIS = 2'd1;
  localparam logic [1:0] ST_ZERO_CT   = 2'd2;
  localparam logic [1:0] ST_BEYOND    = 2'd3;

  localparam logic [2:0] REG_TORQUE_OFF    = 3'd0;
  localparam logic [2:0] REG_TORQUE_UP     = 3'd1;
  localparam logic [2:0] REG_YAW_ZEROED    = 3'd2;
  localparam logic [2:0] REG_THRUST_MAG    = 3'd3;
  localparam logic [2:0] REG_START_COLUMN  = 3'd4;

  localparam logic [16:0] UP_LATERAL_MAX = 17'd6553;
  localparam logic [16:0] UP_VERTICAL_MIN = 17'd32768;

  typedef struct packed {
    logic       torque_off;
    logic       torque_off_unless_upward;
    logic       yaw_row_zeroed;
    logic       thrust_as_magnitude;
    logic [3:0] start_column;
  } rec_cfg_t;

  typedef struct packed {
    logic [4:0]         col;
    logic [1:0]         status;
    logic               last;
    logic [2:0]         neg;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] ct;
    logic signed [31:0] km;
  } rec_side_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ hdl/rec_front.sv @@
module rec_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic [3:0]              start_column_i,
  input  logic [3:0]              rotor_index_i,
  input  logic                    last_rotor_i,
  input  logic signed [31:0]      pos_x_i,
  input  logic signed [31:0]      pos_y_i,
  input  logic signed [31:0]      pos_z_i,
  input  logic signed [31:0]      dir_x_i,
  input  logic signed [31:0]      dir_y_i,
  input  logic signed [31:0]      dir_z_i,
  input  logic signed [31:0]      thrust_coef_i,
  input  logic signed [31:0]      moment_ratio_i,
  output logic                    valid_o,
  output rec_pkg::rec_side_t      side_o,
  output logic [2:0][31:0]        mag_o,
  output logic [63:0]             sum_o
);

  logic               s0_valid_q, s1_valid_q, s2_valid_q, s3_valid_q;
  rec_pkg::rec_side_t side_d, s0_side_q, s1_side_q, s2_side_q, s3_side_q;
  logic [2:0][31:0]   mag_d, s0_mag_q, ms_d, s1_ms_q, s2_ms_q, s3_ms_q;
  logic [2:0][63:0]   s2_sq_q;
  logic [4:0]         col;
  logic [31:0]        mx;
  logic [5:0]         len;
  logic [5:0]         shift_full;
  logic [4:0]         shift;
  logic               pow2;

  always_comb begin
    col = {1'b0, start_column_i} + {1'b0, rotor_index_i};
    mag_d[0] = dir_x_i[31] ? 32'(-dir_x_i) : dir_x_i;
    mag_d[1] = dir_y_i[31] ? 32'(-dir_y_i) : dir_y_i;
    mag_d[2] = dir_z_i[31] ? 32'(-dir_z_i) : dir_z_i;
    side_d.col = col;
    side_d.last = last_rotor_i;
    side_d.neg = {dir_z_i[31], dir_y_i[31], dir_x_i[31]};
    side_d.pos_x = pos_x_i;
    side_d.pos_y = pos_y_i;
    side_d.pos_z = pos_z_i;
    side_d.ct = thrust_coef_i;
    side_d.km = moment_ratio_i;
    if ({1'b0, col} >= 6'(rec_pkg::TABLE_COLUMNS) ||
        {2'b0, rotor_index_i} >= 6'(rec_pkg::MAX_ROTORS)) begin
      side_d.status = rec_pkg::ST_BEYOND;
    end else if (dir_x_i == 32'sd0 && dir_y_i == 32'sd0 && dir_z_i == 32'sd0) begin
      side_d.status = rec_pkg::ST_ZERO_AXIS;
    end else if (thrust_coef_i == 32'sd0) begin
      side_d.status = rec_pkg::ST_ZERO_CT;
    end else begin
      side_d.status = rec_pkg::ST_WRITTEN;
    end
  end

  always_comb begin
    mx = s0_mag_q[0];
    if (s0_mag_q[1] > mx) begin
      mx = s0_mag_q[1];
    end
    if (s0_mag_q[2] > mx) begin
      mx = s0_mag_q[2];
    end
    len = 6'd0;
    for (int i = 0; i < 32; i++) begin
      if (mx[i]) begin
        len = 6'(i + 1);
      end
    end
    pow2 = (mx & (mx - 32'd1)) == 32'd0;
    shift_full = pow2 ? (6'd32 - len) : (6'd31 - len);
    shift = shift_full[4:0];
    for (int i = 0; i < 3; i++) begin
      ms_d[i] = s0_mag_q[i] << shift;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= valid_i;
      s1_valid_q <= s0_valid_q;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_side_q <= side_d;
    s0_mag_q  <= mag_d;
    s1_side_q <= s0_side_q;
    s1_ms_q   <= ms_d;
    s2_side_q <= s1_side_q;
    s2_ms_q   <= s1_ms_q;
    for (int i = 0; i < 3; i++) begin
      s2_sq_q[i] <= s1_ms_q[i] * s1_ms_q[i];
    end
    s3_side_q <= s2_side_q;
    s3_ms_q   <= s2_ms_q;
    sum_o     <= s2_sq_q[0] + s2_sq_q[1] + s2_sq_q[2];
  end

  assign valid_o = s3_valid_q;
  assign side_o  = s3_side_q;
  assign mag_o   = s3_ms_q;

endmodule

@@ hdl/rec_isqrt.sv @@
module rec_isqrt (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  rec_pkg::rec_side_t      side_i,
  input  logic [2:0][31:0]        mag_i,
  input  logic [63:0]             sum_i,
  output logic                    valid_o,
  output rec_pkg::rec_side_t      side_o,
  output logic [2:0][31:0]        mag_o,
  output logic [31:0]             root_o
);

  localparam int unsigned N = rec_pkg::SQRT_STAGES;

  logic               valid_q [N];
  rec_pkg::rec_side_t side_q  [N];
  logic [2:0][31:0]   mag_q   [N];
  logic [63:0]        v_q     [N];
  logic [63:0]        r_q     [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic [63:0] BIT = 64'(1) << (62 - 2 * i);
    logic               valid_in;
    rec_pkg::rec_side_t side_in;
    logic [2:0][31:0]   mag_in;
    logic [63:0]        v_in, r_in, trial;

    if (i == 0) begin : g_first
      assign valid_in = valid_i;
      assign side_in  = side_i;
      assign mag_in   = mag_i;
      assign v_in     = sum_i;
      assign r_in     = 64'd0;
    end else begin : g_next
      assign valid_in = valid_q[i-1];
      assign side_in  = side_q[i-1];
      assign mag_in   = mag_q[i-1];
      assign v_in     = v_q[i-1];
      assign r_in     = r_q[i-1];
    end

    assign trial = r_in + BIT;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else begin
        valid_q[i] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[i] <= side_in;
      mag_q[i]  <= mag_in;
      if (v_in >= trial) begin
        v_q[i] <= v_in - trial;
        r_q[i] <= (r_in >> 1) + BIT;
      end else begin
        v_q[i] <= v_in;
        r_q[i] <= r_in >> 1;
      end
    end
  end

  assign valid_o = valid_q[N-1];
  assign side_o  = side_q[N-1];
  assign mag_o   = mag_q[N-1];
  assign root_o  = r_q[N-1][31:0];

endmodule

@@ hdl/rec_div.sv @@
module rec_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  rec_pkg::rec_side_t      side_i,
  input  logic [2:0][31:0]        mag_i,
  input  logic [31:0]             root_i,
  output logic                    valid_o,
  output rec_pkg::rec_side_t      side_o,
  output logic [2:0][16:0]        quot_o
);

  localparam int unsigned N = rec_pkg::QUOT_BITS;

  logic               valid_q [N];
  rec_pkg::rec_side_t side_q  [N];
  logic [31:0]        n_q     [N];
  logic [2:0][47:0]   rem_q   [N];
  logic [2:0][16:0]   quot_q  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int unsigned B = N - 1 - k;
    logic               valid_in;
    rec_pkg::rec_side_t side_in;
    logic [31:0]        n_in;
    logic [2:0][47:0]   rem_in, rem_d;
    logic [2:0][16:0]   quot_in, quot_d;
    logic [48:0]        trial;
    logic [48:0]        diff;

    if (k == 0) begin : g_first
      assign valid_in = valid_i;
      assign side_in  = side_i;
      assign n_in     = root_i;
      assign quot_in  = '0;
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign rem_in[l] = {mag_i[l], 16'd0};
      end
    end else begin : g_next
      assign valid_in = valid_q[k-1];
      assign side_in  = side_q[k-1];
      assign n_in     = n_q[k-1];
      assign rem_in   = rem_q[k-1];
      assign quot_in  = quot_q[k-1];
    end

    always_comb begin
      trial = 49'(n_in) << B;
      diff  = '0;
      for (int l = 0; l < 3; l++) begin
        diff = {1'b0, rem_in[l]} - trial;
        if ({1'b0, rem_in[l]} >= trial) begin
          rem_d[l]  = diff[47:0];
          quot_d[l] = {quot_in[l][15:0], 1'b1};
        end else begin
          rem_d[l]  = rem_in[l];
          quot_d[l] = {quot_in[l][15:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[k] <= side_in;
      n_q[k]    <= n_in;
      rem_q[k]  <= rem_d;
      quot_q[k] <= quot_d;
    end
  end

  assign valid_o = valid_q[N-1];
  assign side_o  = side_q[N-1];
  assign quot_o  = quot_q[N-1];

endmodule

@@ hdl/rec_column.sv @@
module rec_column (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rec_pkg::rec_cfg_t       cfg_i,
  input  logic                    valid_i,
  input  rec_pkg::rec_side_t      side_i,
  input  logic [2:0][16:0]        quot_i,
  output logic                    done_o,
  output logic [4:0]              column_o,
  output logic [1:0]              status_o,
  output logic signed [31:0]      moment_x_o,
  output logic signed [31:0]      moment_y_o,
  output logic signed [31:0]      moment_z_o,
  output logic signed [31:0]      force_x_o,
  output logic signed [31:0]      force_y_o,
  output logic signed [31:0]      force_z_o,
  output logic                    last_o
);

  logic c1_valid_q, c2_valid_q, c3_valid_q;
  rec_pkg::rec_side_t c1_side_q, c2_side_q, c3_side_q;

  logic signed [17:0] u_d [3];
  logic signed [17:0] c1_u_q [3], c2_u_q [3];
  logic signed [31:0] px, py, pz, ct1, km_eff;
  logic               upward;
  logic signed [49:0] cross_d [6], c1_cross_q [6];
  logic signed [49:0] fp_d [3], c1_fp_q [3];
  logic signed [63:0] ctkm_d, c1_ctkm_q;

  logic signed [50:0] cdiff [3];
  logic signed [63:0] cwide [3];
  logic signed [63:0] fwide [3];
  logic signed [63:0] ckwide;
  logic signed [31:0] c_d [3], c2_c_q [3];
  logic signed [31:0] f_d [3], c2_f_q [3], c3_f_q [3];
  logic signed [47:0] ck_d, c2_ck_q;

  logic signed [31:0] ct3;
  logic signed [63:0] mc_d [3], mk_d [3], c3_mc_q [3], c3_mk_q [3];

  logic signed [31:0] ct4;
  logic signed [63:0] mwide [3];
  logic signed [63:0] nct;
  logic signed [31:0] mo_d [3], fo_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_d[i] = side_i.neg[i] ? -$signed({1'b0, quot_i[i]}) : $signed({1'b0, quot_i[i]});
    end
    upward = quot_i[0] <= rec_pkg::UP_LATERAL_MAX && quot_i[1] <= rec_pkg::UP_LATERAL_MAX &&
             side_i.neg[2] && quot_i[2] > rec_pkg::UP_VERTICAL_MIN;
    px  = side_i.pos_x;
    py  = side_i.pos_y;
    pz  = side_i.pos_z;
    ct1 = side_i.ct;
    if (cfg_i.torque_off || (cfg_i.torque_off_unless_upward && !upward)) begin
      km_eff = 32'sd0;
    end else begin
      km_eff = side_i.km;
    end
    cross_d[0] = py * u_d[2];
    cross_d[1] = pz * u_d[1];
    cross_d[2] = pz * u_d[0];
    cross_d[3] = px * u_d[2];
    cross_d[4] = px * u_d[1];
    cross_d[5] = py * u_d[0];
    for (int i = 0; i < 3; i++) begin
      fp_d[i] = ct1 * u_d[i];
    end
    ctkm_d = ct1 * km_eff;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cdiff[i] = c1_cross_q[2*i] - c1_cross_q[2*i+1];
      cwide[i] = cdiff[i] >>> 16;
      c_d[i]   = rec_pkg::sat32(cwide[i]);
      fwide[i] = c1_fp_q[i] >>> 16;
      f_d[i]   = rec_pkg::sat32(fwide[i]);
    end
    ckwide = c1_ctkm_q >>> 16;
    ck_d   = ckwide[47:0];
  end

  always_comb begin
    ct3 = c2_side_q.ct;
    for (int i = 0; i < 3; i++) begin
      mc_d[i] = ct3 * c2_c_q[i];
      mk_d[i] = c2_ck_q * c2_u_q[i];
    end
  end

  always_comb begin
    ct4 = c3_side_q.ct;
    nct = 64'sd0 - ct4;
    for (int i = 0; i < 3; i++) begin
      mwide[i] = (c3_mc_q[i] >>> 16) - (c3_mk_q[i] >>> 16);
      mo_d[i]  = rec_pkg::sat32(mwide[i]);
      fo_d[i]  = c3_f_q[i];
    end
    if (cfg_i.yaw_row_zeroed) begin
      mo_d[2] = 32'sd0;
    end
    if (cfg_i.thrust_as_magnitude) begin
      fo_d[0] = 32'sd0;
      fo_d[1] = 32'sd0;
      fo_d[2] = rec_pkg::sat32(nct);
    end
    if (c3_side_q.status != rec_pkg::ST_WRITTEN) begin
      for (int i = 0; i < 3; i++) begin
        mo_d[i] = 32'sd0;
        fo_d[i] = 32'sd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_valid_q <= 1'b0;
      c2_valid_q <= 1'b0;
      c3_valid_q <= 1'b0;
      done_o     <= 1'b0;
    end else begin
      c1_valid_q <= valid_i;
      c2_valid_q <= c1_valid_q;
      c3_valid_q <= c2_valid_q;
      done_o     <= c3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c1_side_q <= side_i;
    c1_ctkm_q <= ctkm_d;
    c2_side_q <= c1_side_q;
    c2_ck_q   <= ck_d;
    c3_side_q <= c2_side_q;
    for (int i = 0; i < 6; i++) begin
      c1_cross_q[i] <= cross_d[i];
    end
    for (int i = 0; i < 3; i++) begin
      c1_u_q[i]  <= u_d[i];
      c1_fp_q[i] <= fp_d[i];
      c2_u_q[i]  <= c1_u_q[i];
      c2_c_q[i]  <= c_d[i];
      c2_f_q[i]  <= f_d[i];
      c3_mc_q[i] <= mc_d[i];
      c3_mk_q[i] <= mk_d[i];
      c3_f_q[i]  <= c2_f_q[i];
    end
    column_o   <= c3_side_q.col;
    status_o   <= c3_side_q.status;
    last_o     <= c3_side_q.last;
    moment_x_o <= mo_d[0];
    moment_y_o <= mo_d[1];
    moment_z_o <= mo_d[2];
    force_x_o  <= fo_d[0];
    force_y_o  <= fo_d[1];
    force_z_o  <= fo_d[2];
  end

endmodule

@@ hdl/rotor_effectiveness_column_top.sv @@
// Each accepted request passes the front, square root, divider and column pipelines.
// Throughput: one request per cycle; busy stays low, and the receiver cannot stall.
// Latency sums the front, 32-stage square root, 17-stage divider and column stages.
// Reset clears the pipeline valid bits and sets all configuration registers to zero.
module rotor_effectiveness_column_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         rotor_index_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] dir_x_i,
  input  logic signed [31:0] dir_y_i,
  input  logic signed [31:0] dir_z_i,
  input  logic signed [31:0] thrust_coef_i,
  input  logic signed [31:0] moment_ratio_i,
  input  logic               last_rotor_i,
  output logic               done_o,
  output logic [4:0]         column_o,
  output logic [1:0]         status_o,
  output logic signed [31:0] moment_x_o,
  output logic signed [31:0] moment_y_o,
  output logic signed [31:0] moment_z_o,
  output logic signed [31:0] force_x_o,
  output logic signed [31:0] force_y_o,
  output logic signed [31:0] force_z_o,
  output logic               last_o
);

  rec_pkg::rec_cfg_t  cfg_q;
  logic [2:0]         reg_index;
  logic               wr_en;

  logic               fr_valid, sq_valid, dv_valid;
  rec_pkg::rec_side_t fr_side, sq_side, dv_side;
  logic [2:0][31:0]   fr_mag, sq_mag;
  logic [63:0]        fr_sum;
  logic [31:0]        sq_root;
  logic [2:0][16:0]   dv_quot;

  assign pready    = 1'b1;
  assign busy      = 1'b0;
  assign reg_index = paddr[4:2];
  assign wr_en     = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (reg_index)
        rec_pkg::REG_TORQUE_OFF:   cfg_q.torque_off <= pwdata[0];
        rec_pkg::REG_TORQUE_UP:    cfg_q.torque_off_unless_upward <= pwdata[0];
        rec_pkg::REG_YAW_ZEROED:   cfg_q.yaw_row_zeroed <= pwdata[0];
        rec_pkg::REG_THRUST_MAG:   cfg_q.thrust_as_magnitude <= pwdata[0];
        rec_pkg::REG_START_COLUMN: cfg_q.start_column <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      rec_pkg::REG_TORQUE_OFF:   prdata = {31'd0, cfg_q.torque_off};
      rec_pkg::REG_TORQUE_UP:    prdata = {31'd0, cfg_q.torque_off_unless_upward};
      rec_pkg::REG_YAW_ZEROED:   prdata = {31'd0, cfg_q.yaw_row_zeroed};
      rec_pkg::REG_THRUST_MAG:   prdata = {31'd0, cfg_q.thrust_as_magnitude};
      rec_pkg::REG_START_COLUMN: prdata = {28'd0, cfg_q.start_column};
      default:                   prdata = 32'd0;
    endcase
  end

  rec_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (start && !busy),
    .start_column_i (cfg_q.start_column),
    .rotor_index_i  (rotor_index_i),
    .last_rotor_i   (last_rotor_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pos_z_i        (pos_z_i),
    .dir_x_i        (dir_x_i),
    .dir_y_i        (dir_y_i),
    .dir_z_i        (dir_z_i),
    .thrust_coef_i  (thrust_coef_i),
    .moment_ratio_i (moment_ratio_i),
    .valid_o        (fr_valid),
    .side_o         (fr_side),
    .mag_o          (fr_mag),
    .sum_o          (fr_sum)
  );

  rec_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .side_i  (fr_side),
    .mag_i   (fr_mag),
    .sum_i   (fr_sum),
    .valid_o (sq_valid),
    .side_o  (sq_side),
    .mag_o   (sq_mag),
    .root_o  (sq_root)
  );

  rec_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_valid),
    .side_i  (sq_side),
    .mag_i   (sq_mag),
    .root_i  (sq_root),
    .valid_o (dv_valid),
    .side_o  (dv_side),
    .quot_o  (dv_quot)
  );

  rec_column u_column (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .valid_i    (dv_valid),
    .side_i     (dv_side),
    .quot_i     (dv_quot),
    .done_o     (done_o),
    .column_o   (column_o),
    .status_o   (status_o),
    .moment_x_o (moment_x_o),
    .moment_y_o (moment_y_o),
    .moment_z_o (moment_z_o),
    .force_x_o  (force_x_o),
    .force_y_o  (force_y_o),
    .force_z_o  (force_z_o),
    .last_o     (last_o)
  );

`ifndef SYNTHESIS
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(rec_pkg::LATENCY) done_o)
    else $error("A request did not complete after the pipeline latency.");

  a_skip_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != rec_pkg::ST_WRITTEN) |->
      (moment_x_o == 32'sd0 && moment_y_o == 32'sd0 && moment_z_o == 32'sd0 &&
       force_x_o == 32'sd0 && force_y_o == 32'sd0 && force_z_o == 32'sd0))
    else $error("A skipped column carries nonzero entries.");

  a_thrust_mag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && cfg_q.thrust_as_magnitude) |-> (force_x_o == 32'sd0 && force_y_o == 32'sd0))
    else $error("Lateral thrust entries are nonzero in magnitude mode.");
`endif

endmodule

@@ tb/rotor_effectiveness_column_checker.sv @@
module rotor_effectiveness_column_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               start,
  input  logic               busy,
  input  logic [3:0]         rotor_index_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] dir_x_i,
  input  logic signed [31:0] dir_y_i,
  input  logic signed [31:0] dir_z_i,
  input  logic signed [31:0] thrust_coef_i,
  input  logic signed [31:0] moment_ratio_i,
  input  logic               last_rotor_i,
  input  logic               done_o,
  input  logic [4:0]         column_o,
  input  logic [1:0]         status_o,
  input  logic signed [31:0] moment_x_o,
  input  logic signed [31:0] moment_y_o,
  input  logic signed [31:0] moment_z_o,
  input  logic signed [31:0] force_x_o,
  input  logic signed [31:0] force_y_o,
  input  logic signed [31:0] force_z_o,
  input  logic               last_o,
  output int                 errors,
  output int                 pending,
  output int                 columns_seen,
  output int                 written_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [4:0]         col;
    logic [1:0]         status;
    logic signed [31:0] mo [3];
    logic signed [31:0] fo [3];
    logic               last;
  } column_t;

  rec_pkg::rec_cfg_t cfg;
  column_t           expected_columns [$];

  function automatic longint sat_q16(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned magnitude(input longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic column_t predict_column(
    input logic [3:0] ridx, input logic signed [31:0] px, py, pz, dx, dy, dz,
    input logic signed [31:0] ct32, km32, input logic lst);
    column_t r;
    longint p [3];
    longint d [3];
    longint u [3];
    longint c [3];
    longint ct, km, ck;
    longint unsigned m [3];
    longint unsigned mx, sum, n, b, rem;
    int s;
    logic up;
    r.col = {1'b0, cfg.start_column} + {1'b0, ridx};
    r.last = lst;
    r.status = rec_pkg::ST_WRITTEN;
    for (int i = 0; i < 3; i++) begin
      r.mo[i] = '0;
      r.fo[i] = '0;
    end
    p[0] = px; p[1] = py; p[2] = pz;
    d[0] = dx; d[1] = dy; d[2] = dz;
    ct = ct32;
    km = km32;
    if (r.col >= rec_pkg::TABLE_COLUMNS || ridx >= rec_pkg::MAX_ROTORS) begin
      r.status = rec_pkg::ST_BEYOND;
    end else if (dx == 0 && dy == 0 && dz == 0) begin
      r.status = rec_pkg::ST_ZERO_AXIS;
    end else if (ct == 0) begin
      r.status = rec_pkg::ST_ZERO_CT;
    end else begin
      mx = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = magnitude(d[i]);
        if (m[i] > mx) mx = m[i];
      end
      s = 0;
      while (s < 31 && (mx << (s + 1)) <= 64'h8000_0000) s++;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = m[i] << s;
        sum += m[i] * m[i];
      end
      n = 0;
      rem = sum;
      b = 64'd1 << 62;
      while (b > rem) b >>= 2;
      while (b != 0) begin
        if (rem >= n + b) begin
          rem -= n + b;
          n = (n >> 1) + b;
        end else begin
          n >>= 1;
        end
        b >>= 2;
      end
      for (int i = 0; i < 3; i++) begin
        u[i] = longint'((m[i] * 65536) / n);
        if (d[i] < 0) u[i] = -u[i];
      end
      if (cfg.torque_off) km = 0;
      if (cfg.torque_off_unless_upward) begin
        up = magnitude(u[0]) * 10 < 65536 && magnitude(u[1]) * 10 < 65536 && u[2] < -32768;
        if (!up) km = 0;
      end
      ck = (ct * km) >>> 16;
      c[0] = sat_q16((p[1] * u[2] - p[2] * u[1]) >>> 16);
      c[1] = sat_q16((p[2] * u[0] - p[0] * u[2]) >>> 16);
      c[2] = sat_q16((p[0] * u[1] - p[1] * u[0]) >>> 16);
      for (int i = 0; i < 3; i++) begin
        r.mo[i] = 32'(sat_q16(((ct * c[i]) >>> 16) - ((ck * u[i]) >>> 16)));
        r.fo[i] = 32'(sat_q16((ct * u[i]) >>> 16));
      end
      if (cfg.yaw_row_zeroed) r.mo[2] = '0;
      if (cfg.thrust_as_magnitude) begin
        r.fo[0] = '0;
        r.fo[1] = '0;
        r.fo[2] = 32'(sat_q16(-ct));
      end
    end
    return r;
  endfunction

  task automatic compare_field(input string name, input longint e, input longint a);
    if (e != a) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      errors++;
    end
  endtask

  assign pending = expected_columns.size();

  always @(posedge clk_i or negedge rst_ni) begin
    column_t e;
    if (!rst_ni) begin
      cfg <= '0;
      expected_columns.delete();
      errors = 0;
      columns_seen = 0;
      written_seen = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          rec_pkg::REG_TORQUE_OFF:   cfg.torque_off <= pwdata[0];
          rec_pkg::REG_TORQUE_UP:    cfg.torque_off_unless_upward <= pwdata[0];
          rec_pkg::REG_YAW_ZEROED:   cfg.yaw_row_zeroed <= pwdata[0];
          rec_pkg::REG_THRUST_MAG:   cfg.thrust_as_magnitude <= pwdata[0];
          rec_pkg::REG_START_COLUMN: cfg.start_column <= pwdata[3:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        expected_columns.push_back(predict_column(rotor_index_i, pos_x_i, pos_y_i, pos_z_i,
          dir_x_i, dir_y_i, dir_z_i, thrust_coef_i, moment_ratio_i, last_rotor_i));
      end
      if (done_o) begin
        columns_seen++;
        if (expected_columns.size() == 0) begin
          $error("Result arrived with no request outstanding.");
          errors++;
        end else begin
          e = expected_columns.pop_front();
          if (e.status == rec_pkg::ST_WRITTEN) written_seen++;
          compare_field("column", e.col, column_o);
          compare_field("status", e.status, status_o);
          compare_field("moment_x", e.mo[0], moment_x_o);
          compare_field("moment_y", e.mo[1], moment_y_o);
          compare_field("moment_z", e.mo[2], moment_z_o);
          compare_field("force_x", e.fo[0], force_x_o);
          compare_field("force_y", e.fo[1], force_y_o);
          compare_field("force_z", e.fo[2], force_z_o);
          compare_field("last", e.last, last_o);
        end
      end
    end
  end

endmodule

@@ tb/tb_rotor_effectiveness_column_top.sv @@
module tb_rotor_effectiveness_column_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk_i;
  logic               rst_ni;
  logic               psel, penable, pwrite;
  logic [4:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               start;
  logic               busy;
  logic [3:0]         rotor_index_i;
  logic signed [31:0] pos_x_i, pos_y_i, pos_z_i;
  logic signed [31:0] dir_x_i, dir_y_i, dir_z_i;
  logic signed [31:0] thrust_coef_i, moment_ratio_i;
  logic               last_rotor_i;
  logic               done_o;
  logic [4:0]         column_o;
  logic [1:0]         status_o;
  logic signed [31:0] moment_x_o, moment_y_o, moment_z_o;
  logic signed [31:0] force_x_o, force_y_o, force_z_o;
  logic               last_o;
  int                 errors, pending, columns_seen, written_seen;
  int                 setting_count;
  logic               no_gaps;

  rotor_effectiveness_column_top uut (.*);

  rotor_effectiveness_column_checker column_checker (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  function automatic logic signed [31:0] random_q16();
    int unsigned k;
    logic signed [31:0] v;
    k = $urandom_range(0, 9);
    v = $urandom();
    case (k)
      0: v = 32'sh8000_0000;
      1: v = 32'sh7FFF_FFFF;
      2: v = 0;
      3, 4, 5: v = v >>> $urandom_range(8, 31);
      default: ;
    endcase
    return v;
  endfunction

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (rec_pkg::LATENCY + 8) @(posedge clk_i);
  endtask

  task automatic apply_setting(input logic [4:0] flags_col);
    drain();
    cfg_write(rec_pkg::REG_TORQUE_OFF, {31'd0, flags_col[4]});
    cfg_write(rec_pkg::REG_TORQUE_UP, {31'd0, flags_col[3]});
    cfg_write(rec_pkg::REG_YAW_ZEROED, {31'd0, flags_col[2]});
    cfg_write(rec_pkg::REG_THRUST_MAG, {31'd0, flags_col[1]});
    cfg_write(rec_pkg::REG_START_COLUMN, $urandom_range(0, 15));
    setting_count++;
  endtask

  task automatic send_rotor(input logic [3:0] ridx, input logic signed [31:0] px, py, pz,
                            input logic signed [31:0] dx, dy, dz, ct, km, input logic lst);
    rotor_index_i <= ridx;
    pos_x_i <= px;
    pos_y_i <= py;
    pos_z_i <= pz;
    dir_x_i <= dx;
    dir_y_i <= dy;
    dir_z_i <= dz;
    thrust_coef_i <= ct;
    moment_ratio_i <= km;
    last_rotor_i <= lst;
    start <= 1'b1;
    forever begin
      @(negedge clk_i);
      if (!busy) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
  endtask

  task automatic idle_gap();
    int unsigned r, n;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) n = 0;
    else if (r < 90) n = $urandom_range(1, 3);
    else if (r < 98) n = $urandom_range(4, 12);
    else n = $urandom_range(20, 90);
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_random_rotor();
    logic signed [31:0] dx, dy, dz, ct;
    int unsigned k;
    dx = random_q16();
    dy = random_q16();
    dz = random_q16();
    ct = random_q16();
    k = $urandom_range(0, 19);
    if (k < 6) begin
      dz = -$signed({1'b0, 31'($urandom_range(32768, 32'h7FFF_FFFF))}) >>> $urandom_range(0, 14);
      dx = $signed(32'($urandom_range(0, 2 * (-dz / 9)))) + dz / 9;
      dy = $signed(32'($urandom_range(0, 2 * (-dz / 9)))) + dz / 9;
    end else if (k == 6) begin
      dx = 0; dy = 0; dz = 0;
    end else if (k == 7) begin
      ct = 0;
    end
    send_rotor($urandom_range(0, 15), random_q16(), random_q16(), random_q16(),
               dx, dy, dz, ct, random_q16(), $urandom_range(0, 1));
    idle_gap();
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    start = 1'b0; rotor_index_i = '0; last_rotor_i = 1'b0;
    pos_x_i = '0; pos_y_i = '0; pos_z_i = '0;
    dir_x_i = '0; dir_y_i = '0; dir_z_i = '0;
    thrust_coef_i = '0; moment_ratio_i = '0;
    setting_count = 0;
    no_gaps = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_rotor(0, 32'sh0001_0000, 0, 0, 0, 0, -32'sh0001_0000, 32'sh0000_8000, 32'sh0000_1000, 0);
    send_rotor(11, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1, -1, 1,
               32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1);
    send_rotor(5, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
               32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0);
    send_rotor(3, 5, 6, 7, 0, 0, 0, 32'sh0001_0000, 1, 0);
    send_rotor(4, 5, 6, 7, 1, 2, 3, 0, 1, 1);
    send_rotor(12, 5, 6, 7, 1, 2, 3, 9, 1, 0);
    send_rotor(15, 5, 6, 7, 1, 2, 3, 9, 1, 1);
    send_rotor(2, 32'sh7FFF_FFFF, -32'sh7FFF_FFFF, 32'sh4000_0000, 32'sh7FFF_FFFF, 0, 0,
               32'sh7FFF_FFFF, -32'sh0001_0000, 0);
    send_rotor(6, 32'sh0002_0000, -32'sh0003_0000, 32'sh0000_4000, 6553, 6553, -65536,
               32'sh0001_8000, 32'sh0000_0CCC, 0);
    send_rotor(7, 32'sh0002_0000, -32'sh0003_0000, 32'sh0000_4000, 6554, 0, -65536,
               32'sh0001_8000, 32'sh0000_0CCC, 0);
    send_rotor(8, 1, 1, 1, 0, 0, 32'sh7FFF_FFFF, -32'sh0000_0001, -1, 1);
    send_rotor(1, 0, 0, 0, 0, 1, 0, 32'sh8000_0000, 0, 0);
    start <= 1'b0;

    apply_setting(5'b11111);
    cfg_write(rec_pkg::REG_START_COLUMN, 15);
    send_rotor(0, 7, 8, 9, 1, 0, 0, 32'sh8000_0000, 5, 1);
    send_rotor(1, 7, 8, 9, 1, 0, 0, 32'sh8000_0000, 5, 1);
    send_rotor(0, 32'sh0001_0000, 32'sh0001_0000, 0, 0, 0, -1, 32'sh0001_0000, 32'sh0001_0000, 0);
    start <= 1'b0;
    apply_setting(5'b01000);
    cfg_write(rec_pkg::REG_START_COLUMN, 4);
    send_rotor(11, 32'sh0001_0000, 32'sh0001_0000, 0, 1, 1, -100, 32'sh0001_0000,
               32'sh0001_0000, 0);
    send_rotor(2, 32'sh0001_0000, 32'sh0001_0000, 0, 0, 0, -7, 32'sh7FFF_FFFF,
               32'sh7FFF_FFFF, 1);
    start <= 1'b0;

    for (int phase = 0; phase < 8; phase++) begin
      apply_setting((phase == 0) ? 5'b00000 : (phase == 1) ? 5'b11110 : 5'($urandom()));
      for (int i = 0; i < 210; i++) begin
        if (i % 70 == 0) no_gaps = ($urandom_range(0, 2) == 0);
        if (i == 105) begin
          start <= 1'b0;
          while (pending != 0) @(posedge clk_i);
        end
        send_random_rotor();
      end
      start <= 1'b0;
    end

    drain();
    $display("Checked %0d columns (%0d written) across %0d register settings.",
             columns_seen, written_seen, setting_count);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/rec_pkg.sv
hdl/rec_front.sv
hdl/rec_isqrt.sv
hdl/rec_div.sv
hdl/rec_column.sv
hdl/rotor_effectiveness_column_top.sv
tb/rotor_effectiveness_column_checker.sv
tb/tb_rotor_effectiveness_column_top.sv
